// File: hw/rtl/cgs_pkg.sv
// Shared types, constants and width helpers for the color gradient stepper.
`timescale 1ns / 1ps
`default_nettype none

package cgs_pkg;

    // Color channel layout.
    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = CHAN_W + FRAC_W;

    // Default for the largest supported gradient length.
    localparam int MAX_STEPS_DEF = 4096;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_CNT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_MODE   = 2'd3;

    // Stream payload widths.
    localparam int STEP_NUM_W = 12;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    // Width that holds any step count from 0 to max_steps.
    function automatic int steps_width(input int max_steps);
        steps_width = $clog2(max_steps + 1);
    endfunction

    // Divider width: the cubic product or the scaled channel difference.
    function automatic int div_width(input int max_steps);
        int w;
        w = 3 * steps_width(max_steps) + CHAN_W;
        div_width = (w > ACC_W) ? w : ACC_W;
    endfunction

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_FINISH
    } cgs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic finish;
    } cgs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } cgs_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/cgs_div.sv
// Restoring unsigned divider lane, one quotient bit per cycle while step is asserted.
`timescale 1ns / 1ps
`default_nettype none

module cgs_div #(
    parameter int W = 47
) (
    input  wire logic         clk,
    input  wire logic         load,
    input  wire logic         step,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output logic              rem_nz
);

    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_reg;
    logic [W-1:0] quo_next;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = '0;
            quo_next = dividend;
        end
        else if (step)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign rem_nz   = |rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cgs_ctrl.sv
// Controller state machine that sequences each gradient step.
`timescale 1ns / 1ps
`default_nettype none

module cgs_ctrl #(
    parameter int DIV_W = 47
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cgs_pkg::cgs_status_t status,
    output cgs_pkg::cgs_cmd_t        cmd
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    cgs_pkg::cgs_state_t state_reg;
    cgs_pkg::cgs_state_t state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    // State and iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            cgs_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = cgs_pkg::ST_MUL_A;
                end
            end
            cgs_pkg::ST_MUL_A:
            begin
                // Plain accumulator steps need no division.
                state_next = status.need_div ? cgs_pkg::ST_MUL_B : cgs_pkg::ST_FINISH;
            end
            cgs_pkg::ST_MUL_B:
            begin
                state_next = cgs_pkg::ST_MUL_C;
            end
            cgs_pkg::ST_MUL_C:
            begin
                state_next = cgs_pkg::ST_MUL_D;
            end
            cgs_pkg::ST_MUL_D:
            begin
                state_next = cgs_pkg::ST_DIV_LOAD;
            end
            cgs_pkg::ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = CNT_W'(DIV_W);
                state_next   = cgs_pkg::ST_DIV_RUN;
            end
            cgs_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = cgs_pkg::ST_FINISH;
                end
            end
            cgs_pkg::ST_FINISH:
            begin
                // Wait until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = cgs_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/cgs_datapath.sv
// Datapath: step index, channel accumulators, cubic terms, divider lanes, output register.
`timescale 1ns / 1ps
`default_nettype none

module cgs_datapath #(
    parameter int MAX_STEPS = cgs_pkg::MAX_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cgs_pkg::cgs_cmd_t                  cmd,
    output cgs_pkg::cgs_status_t                    status,
    input  wire logic                               restart,
    input  wire logic [31:0]                        start_color,
    input  wire logic [31:0]                        end_color,
    input  wire logic [cgs_pkg::STEP_CNT_W-1:0]     step_count,
    input  wire logic                               quad_mode,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [cgs_pkg::M_TDATA_W-1:0]           out_data,
    output logic                                    out_last
);

    localparam int NW    = cgs_pkg::steps_width(MAX_STEPS);
    localparam int IW    = $clog2(MAX_STEPS);
    localparam int CW    = (NW > cgs_pkg::STEP_CNT_W) ? NW : cgs_pkg::STEP_CNT_W;
    localparam int PW    = 2 * NW + 2;
    localparam int P3W   = 3 * NW;
    localparam int DVW   = cgs_pkg::div_width(MAX_STEPS);
    localparam int ACC_W = cgs_pkg::ACC_W;
    localparam int CH_W  = cgs_pkg::CHAN_W;
    localparam int NCH   = cgs_pkg::NUM_CHAN;

    // Step index and per-item latches.
    logic [IW-1:0] step_index_reg;
    logic [IW-1:0] step_index_next;
    logic [NW-1:0] cur_idx_reg;
    logic [NW-1:0] n_reg;
    logic          last_reg;
    logic          zero_reg;

    logic [CW-1:0] sc_ext;
    logic [NW-1:0] n_now;
    logic [NW-1:0] idx_ext;
    logic [NW-1:0] idx_now;
    logic [NW-1:0] idx_inc;
    logic [NW-1:0] idx_after;

    // Effective step count, index selection and wrap.
    always_comb
    begin
        sc_ext = CW'(step_count);
        if (sc_ext == '0)
        begin
            n_now = NW'(1);
        end
        else if (sc_ext > CW'(MAX_STEPS))
        begin
            n_now = NW'(MAX_STEPS);
        end
        else
        begin
            n_now = NW'(sc_ext);
        end
        idx_ext         = NW'(step_index_reg);
        idx_now         = (restart || (idx_ext >= n_now)) ? '0 : idx_ext;
        idx_inc         = idx_now + 1'b1;
        idx_after       = (idx_inc >= n_now) ? '0 : idx_inc;
        step_index_next = cmd.accept ? IW'(idx_after) : step_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg <= '0;
        end
        else
        begin
            step_index_reg <= step_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_idx_reg <= idx_now;
            n_reg       <= n_now;
            last_reg    <= (idx_now == (n_now - 1'b1));
            zero_reg    <= (idx_now == '0);
        end
    end

    assign status.need_div = zero_reg || quad_mode;

    // Cubic easing terms; every product and the polynomial are registered.
    logic [2*NW-1:0]   ii_full;
    logic [2*NW-1:0]   in_full;
    logic [2*NW-1:0]   nn_full;
    logic [2*NW-1:0]   ii_reg;
    logic [2*NW-1:0]   in_reg;
    logic [2*NW-1:0]   nn_reg;
    logic [PW-1:0]     poly_next;
    logic [PW-1:0]     poly_reg;
    logic [P3W-1:0]    n3_full;
    logic [P3W-1:0]    n3_reg;
    logic [NW+PW-1:0]  p_full;
    logic [P3W-1:0]    p_reg;

    assign ii_full = (2*NW)'(cur_idx_reg) * (2*NW)'(cur_idx_reg);
    assign in_full = (2*NW)'(cur_idx_reg) * (2*NW)'(n_reg);
    assign nn_full = (2*NW)'(n_reg) * (2*NW)'(n_reg);
    // 4i^2 - 6in + 3n^2 is never negative and stays below 2^PW.
    assign poly_next = (PW'(ii_reg) << 2) + (PW'(nn_reg) << 1) + PW'(nn_reg)
                     - (PW'(in_reg) << 2) - (PW'(in_reg) << 1);
    assign n3_full = P3W'(nn_reg) * P3W'(n_reg);
    assign p_full  = (NW+PW)'(cur_idx_reg) * (NW+PW)'(poly_reg);

    always_ff @(posedge clk)
    begin
        ii_reg   <= ii_full;
        in_reg   <= in_full;
        nn_reg   <= nn_full;
        poly_reg <= poly_next;
        n3_reg   <= n3_full;
        p_reg    <= p_full[P3W-1:0];
    end

    // Channel lanes.
    logic [CH_W-1:0] color_out [NCH];

    for (genvar c = 0; c < NCH; c++)
    begin : g_lane
        logic [CH_W-1:0]  s_c;
        logic [CH_W-1:0]  e_c;
        logic             neg_c;
        logic [CH_W-1:0]  mag_c;
        logic [DVW-1:0]   prod_full;
        logic [DVW-1:0]   prod_reg;
        logic [DVW-1:0]   dividend;
        logic [DVW-1:0]   divisor;
        logic [DVW-1:0]   quo;
        logic             rnz;
        logic [ACC_W-1:0] q24;
        logic [ACC_W-1:0] inc_new;
        logic [ACC_W-1:0] acc_reg;
        logic [ACC_W-1:0] acc_next;
        logic [ACC_W-1:0] inc_reg;
        logic [ACC_W-1:0] inc_next;

        assign s_c   = start_color[c*CH_W +: CH_W];
        assign e_c   = end_color[c*CH_W +: CH_W];
        assign neg_c = (e_c < s_c);
        assign mag_c = neg_c ? (s_c - e_c) : (e_c - s_c);

        // Magnitude of the difference times the cubic numerator.
        assign prod_full = DVW'(mag_c) * DVW'(p_reg);

        always_ff @(posedge clk)
        begin
            prod_reg <= prod_full;
        end

        // Step zero divides the scaled difference by N, other steps the product by N^3.
        assign dividend = zero_reg ? DVW'({mag_c, {cgs_pkg::FRAC_W{1'b0}}}) : prod_reg;
        assign divisor  = zero_reg ? DVW'(n_reg) : DVW'(n3_reg);

        cgs_div #(
            .W (DVW)
        ) u_div (
            .clk      (clk),
            .load     (cmd.div_load),
            .step     (cmd.div_step),
            .dividend (dividend),
            .divisor  (divisor),
            .quotient (quo),
            .rem_nz   (rnz)
        );

        // Increment truncates toward zero; accumulators wrap in 24 bits.
        always_comb
        begin
            q24      = quo[ACC_W-1:0];
            inc_new  = neg_c ? (ACC_W'(0) - q24) : q24;
            acc_next = acc_reg;
            inc_next = inc_reg;
            if (cmd.finish)
            begin
                if (zero_reg)
                begin
                    acc_next = {s_c, {cgs_pkg::FRAC_W{1'b0}}} + inc_new;
                    inc_next = inc_new;
                end
                else
                begin
                    acc_next = acc_reg + inc_reg;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            acc_reg <= acc_next;
            inc_reg <= inc_next;
        end

        // Channel color: start value at step zero, floor of the eased value, or accumulator.
        always_comb
        begin
            if (zero_reg)
            begin
                color_out[c] = s_c;
            end
            else if (quad_mode)
            begin
                color_out[c] = neg_c ? (s_c - quo[CH_W-1:0] - CH_W'(rnz))
                                     : (s_c + quo[CH_W-1:0]);
            end
            else
            begin
                color_out[c] = acc_reg[ACC_W-1:cgs_pkg::FRAC_W];
            end
        end
    end

    // Output register, which frees the input side while a result waits.
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [cgs_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                          m_last_reg;

    assign status.out_free = !m_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_data_reg <= {4'b0000, cgs_pkg::STEP_NUM_W'(cur_idx_reg),
                           color_out[3], color_out[2], color_out[1], color_out[0]};
            m_last_reg <= last_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
    assign out_last  = m_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/color_gradient_stepper_unit.sv
// Top level of the color gradient stepper: configuration registers, controller and datapath.
//
//   Channel   Direction  Signals                                  Transfer
//   s_axis    in         tvalid, tready, tdata                    tvalid & tready
//   m_axis    out        tvalid, tready, tdata, tlast             tvalid & tready
//   cfg       in         cfg_we, cfg_index, cfg_data              cfg_we
//
// One item is in work at a time. A linear step other than step zero passes through ST_MUL_A
// and ST_FINISH. Step zero and every quadratic step also pass through ST_MUL_B to ST_MUL_D,
// ST_DIV_LOAD and ST_DIV_RUN, where the restoring divider lanes produce one quotient bit per cycle.
// A finished result waits in the output register; the next item is taken meanwhile,
// and only its own completion stalls on a full output register.
// Reset clears the step index, the controller, the output valid flag and the configuration registers, step count 1.
`timescale 1ns / 1ps
`default_nettype none

module color_gradient_stepper_unit #(
    parameter int MAX_STEPS = cgs_pkg::MAX_STEPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [cgs_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [0] restart
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [cgs_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // [7:0] red, [15:8] green,
                                                                  // [23:16] blue,
                                                                  // [31:24] alpha,
                                                                  // [43:32] step_number
    output logic                                   m_axis_tlast,
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [cgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DIV_W = cgs_pkg::div_width(MAX_STEPS);

    // Configuration registers.
    logic [31:0]                     start_color_reg;
    logic [31:0]                     end_color_reg;
    logic [cgs_pkg::STEP_CNT_W-1:0]  step_count_reg;
    logic                            quad_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg <= '0;
            end_color_reg   <= '0;
            step_count_reg  <= cgs_pkg::STEP_CNT_W'(1);
            quad_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgs_pkg::REG_START_COLOR: start_color_reg <= cfg_data[31:0];
                cgs_pkg::REG_END_COLOR:   end_color_reg   <= cfg_data[31:0];
                cgs_pkg::REG_STEP_COUNT:  step_count_reg  <= cfg_data[cgs_pkg::STEP_CNT_W-1:0];
                cgs_pkg::REG_QUAD_MODE:   quad_mode_reg   <= cfg_data[0];
            endcase
        end
    end

    cgs_pkg::cgs_cmd_t    cmd;
    cgs_pkg::cgs_status_t status;

    cgs_ctrl #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cgs_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .restart     (s_axis_tdata[0]),
        .start_color (start_color_reg),
        .end_color   (end_color_reg),
        .step_count  (step_count_reg),
        .quad_mode   (quad_mode_reg),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

    // Only one item is in work: a transfer in closes the input until completion.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is still in work");

    // Completion only writes into a free output register.
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result written over a waiting result");

    // A result appears only after a completion.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.finish))
        else $error("output valid without a completed item");

    // Accepting never overlaps with division or completion.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (!cmd.finish && !cmd.div_step && !cmd.div_load))
        else $error("accept overlaps with work on an item");

endmodule

`default_nettype wire
